// File: src/pwpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwpps_pkg: shared constants for the pulse-width parameter packet sender
// Holds command and selector codes, packet framing words, parameter masks
// and the reset values of the timing registers.
// ----------------------------------------------------------------------------
package pwpps_pkg;

	// Command codes carried on the input kind field.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Parameter selector codes.
	localparam logic [1:0] SEL_GAIN2  = 2'd0;
	localparam logic [1:0] SEL_GAIN1  = 2'd1;
	localparam logic [1:0] SEL_OFFSET = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_LONG  = 2'd0;
	localparam logic [1:0] REG_SHORT = 2'd1;
	localparam logic [1:0] REG_GAP   = 2'd2;

	// Function codes placed in the packet.
	localparam logic [1:0] FN_SIMULATE = 2'd1;
	localparam logic [1:0] FN_READ     = 2'd3;

	// Packet framing.
	localparam int unsigned PKT_BITS   = 38;
	localparam logic [11:0] START_WORD = 12'h801;
	localparam logic [11:0] END_WORD   = 12'h7FE;
	localparam logic [1:0]  DUMMY_BITS = 2'h2;

	// Parameter width masks.
	localparam logic [7:0] MASK_GAIN2  = 8'h07;
	localparam logic [7:0] MASK_GAIN1  = 8'h7F;
	localparam logic [7:0] MASK_OFFSET = 8'hFF;

	// Timing register reset values, in ticks.
	localparam logic [15:0] LONG_RESET  = 16'(2 * 51);
	localparam logic [15:0] SHORT_RESET = 16'(2 * 1);
	localparam logic [15:0] GAP_RESET   = 16'(2 * 10 + 1);

endpackage

// File: src/pulse_width_parameter_packet_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_parameter_packet_sender: single-wire parameter packet sender
// Keeps shadow copies of three amplifier parameters and frames write and
// read commands into 38-bit pulse-width coded packets, one tick per beat.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Contents
// ----------+-----------+------------------------------------------------------
// s_axis    | in        | tuser: op; tdata: param_sel, value
// m_axis    | out       | tdata: pin_level, busy_res, read_value, accepted,
//           |           |        rejected
// cfg       | in        | write enable, register index, 16-bit write data
//
// Each input beat is handled when it is taken: the sender state and the result
// register are both updated at the edge that accepts the beat, so a new beat
// can be taken on every clock. The result register is the only stage between
// the two sides; it may be refilled in the same cycle it is drained, so the
// input stalls only when a result is held and the output is not ready.
// Reset (arst_n low) empties the result register, puts the sender in idle,
// clears the shadows and loads the default pulse and gap lengths.
// ----------------------------------------------------------------------------
module pulse_width_parameter_packet_sender (
	input  logic        clk,
	input  logic        arst_n,
	// Input beats.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	input  logic [15:0] s_axis_tdata,   // [1:0] param_sel, [9:2] value, [15:10] zero
	// Result beats.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] pin_level, [1] busy_res,
	                                    // [9:2] read_value, [10] accepted,
	                                    // [11] rejected, [15:12] zero
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Phase of the bit currently on the pin.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	localparam int unsigned PKT_W = pwpps_pkg::PKT_BITS;
	localparam int unsigned CNT_W = $clog2(PKT_W + 1);

	// Timing registers.
	logic [15:0] long_q;
	logic [15:0] short_q;
	logic [15:0] gap_q;

	// Sender state.
	logic [PKT_W-1:0] shift_q;
	logic [CNT_W-1:0] bits_left_q;
	phase_t           phase_q;
	logic [15:0]      phase_cnt_q;
	logic [6:0]       gain1_q;
	logic [2:0]       gain2_q;
	logic [7:0]       offset_q;

	// Result register.
	logic        out_valid_q;
	logic [15:0] out_data_q;

	// Next-state values.
	logic [PKT_W-1:0] shift_d;
	logic [CNT_W-1:0] bits_left_d;
	phase_t           phase_d;
	logic [15:0]      phase_cnt_d;
	logic [6:0]       gain1_d;
	logic [2:0]       gain2_d;
	logic [7:0]       offset_d;

	logic [1:0]       op;
	logic [1:0]       param_sel;
	logic [7:0]       value;
	logic             busy;
	logic             pin;
	logic [7:0]       read_val;
	logic             acc;
	logic             rej;
	logic [7:0]       masked;
	logic [1:0]       fn;
	logic [7:0]       pkt_val;
	logic [PKT_W-1:0] shifted;
	logic [CNT_W-1:0] bits_dec;
	logic             accept;

	assign op        = s_axis_tuser;
	assign param_sel = s_axis_tdata[1:0];
	assign value     = s_axis_tdata[9:2];

	// The result register can take a new beat when empty or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A programmed length of zero behaves as one tick.
	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	assign busy     = (phase_q == PH_HIGH) || (phase_q == PH_GAP);
	assign pin      = (phase_q == PH_HIGH);
	assign shifted  = {shift_q[PKT_W-2:0], 1'b0};
	assign bits_dec = bits_left_q - CNT_W'(1);

	always_comb begin
		shift_d     = shift_q;
		bits_left_d = bits_left_q;
		phase_d     = phase_q;
		phase_cnt_d = phase_cnt_q;
		gain1_d     = gain1_q;
		gain2_d     = gain2_q;
		offset_d    = offset_q;
		read_val    = 8'd0;
		acc         = 1'b0;
		rej         = 1'b0;
		masked      = 8'd0;
		fn          = pwpps_pkg::FN_SIMULATE;
		pkt_val     = 8'd0;

		case (op)
			pwpps_pkg::OP_TICK: begin
				case (phase_q)
					PH_HIGH: begin
						// End of the pulse: drop the pin for the gap.
						if (phase_cnt_q <= 16'd1) begin
							phase_d     = PH_GAP;
							phase_cnt_d = at_least_one(gap_q);
						end else begin
							phase_cnt_d = phase_cnt_q - 16'd1;
						end
					end
					PH_GAP: begin
						// End of the gap: move on to the next bit or finish.
						if (phase_cnt_q <= 16'd1) begin
							shift_d     = shifted;
							bits_left_d = bits_dec;
							if (bits_dec == '0) begin
								phase_d     = PH_IDLE;
								phase_cnt_d = 16'd0;
							end else begin
								phase_d     = PH_HIGH;
								phase_cnt_d = at_least_one(shifted[PKT_W-1] ? long_q : short_q);
							end
						end else begin
							phase_cnt_d = phase_cnt_q - 16'd1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			pwpps_pkg::OP_WRITE, pwpps_pkg::OP_READ: begin
				if (busy) begin
					rej = 1'b1;
				end else if (param_sel == pwpps_pkg::SEL_GAIN2 ||
				             param_sel == pwpps_pkg::SEL_GAIN1 ||
				             param_sel == pwpps_pkg::SEL_OFFSET) begin
					acc = 1'b1;
					case (param_sel)
						pwpps_pkg::SEL_GAIN2: begin
							masked   = value & pwpps_pkg::MASK_GAIN2;
							read_val = {5'd0, gain2_q};
						end
						pwpps_pkg::SEL_GAIN1: begin
							masked   = value & pwpps_pkg::MASK_GAIN1;
							read_val = {1'b0, gain1_q};
						end
						default: begin
							masked   = value & pwpps_pkg::MASK_OFFSET;
							read_val = offset_q;
						end
					endcase
					if (op == pwpps_pkg::OP_WRITE) begin
						fn       = pwpps_pkg::FN_SIMULATE;
						pkt_val  = masked;
						read_val = 8'd0;
						case (param_sel)
							pwpps_pkg::SEL_GAIN2: gain2_d  = masked[2:0];
							pwpps_pkg::SEL_GAIN1: gain1_d  = masked[6:0];
							default:              offset_d = masked;
						endcase
					end else begin
						fn      = pwpps_pkg::FN_READ;
						pkt_val = 8'd0;
					end
					shift_d = {pwpps_pkg::START_WORD, fn, param_sel,
					           pwpps_pkg::DUMMY_BITS, pkt_val, pwpps_pkg::END_WORD};
					bits_left_d = CNT_W'(PKT_W);
					phase_d     = PH_HIGH;
					phase_cnt_d = at_least_one(shift_d[PKT_W-1] ? long_q : short_q);
				end
			end
			default: begin
				// Unused op code: no effect, all flags low.
			end
		endcase
	end

	// Timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= pwpps_pkg::LONG_RESET;
			short_q <= pwpps_pkg::SHORT_RESET;
			gap_q   <= pwpps_pkg::GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pwpps_pkg::REG_LONG:  long_q  <= cfg_data;
				pwpps_pkg::REG_SHORT: short_q <= cfg_data;
				pwpps_pkg::REG_GAP:   gap_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sender state advances only on accepted beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			bits_left_q <= '0;
			phase_q     <= PH_IDLE;
			phase_cnt_q <= 16'd0;
			gain1_q     <= 7'd0;
			gain2_q     <= 3'd0;
			offset_q    <= 8'd0;
		end else if (accept) begin
			shift_q     <= shift_d;
			bits_left_q <= bits_left_d;
			phase_q     <= phase_d;
			phase_cnt_q <= phase_cnt_d;
			gain1_q     <= gain1_d;
			gain2_q     <= gain2_d;
			offset_q    <= offset_d;
		end
	end

	// Result register: pin level before the beat, busy after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {4'd0, rej, acc, read_val,
			               (phase_d == PH_HIGH) || (phase_d == PH_GAP), pin};
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pulse_width_parameter_packet_sender
// Drives tick and command beats with random gaps and output back-pressure,
// predicts every result beat with a cycle-free model of the packet sender,
// and compares each received beat field by field against that prediction.
// ----------------------------------------------------------------------------
module tb;

	// Codes the package leaves unnamed: the spare op code and the spare
	// parameter selector. The block must ignore the first, and the second while idle.
	localparam logic [1:0] OP_NONE  = 2'd3;
	localparam logic [1:0] SEL_NONE = 2'd3;

	// The slowest legal run stays far below this: about fifteen hundred
	// beats, each paying at most one random sender gap and one random stall.
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_ITEMS = 500;

	// Line state of the sender as the predictor tracks it.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_GAP  = 2'd2
	} line_phase_t;

	// One result beat, laid out exactly as m_axis_tdata[11:0].
	typedef struct packed {
		logic       rejected;
		logic       accepted;
		logic [7:0] read_value;
		logic       busy;
		logic       pin;
	} sender_result_t;

	// DUT ports. Every input starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser = pwpps_pkg::OP_TICK;   // [1:0] op
	logic [15:0] s_axis_tdata = '0;        // [1:0] param_sel, [9:2] value, [15:10] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;             // [0] pin_level, [1] busy_res,
	                                       // [9:2] read_value, [10] accepted,
	                                       // [11] rejected, [15:12] zero
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = pwpps_pkg::REG_LONG;
	logic [15:0] cfg_data = '0;

	// Predictor copy of the timing registers, starting from their reset values.
	logic [15:0] long_len  = pwpps_pkg::LONG_RESET;
	logic [15:0] short_len = pwpps_pkg::SHORT_RESET;
	logic [15:0] gap_len   = pwpps_pkg::GAP_RESET;

	// Predictor copy of the sender state.
	line_phase_t ph = PH_IDLE;
	logic [15:0] ph_left = '0;
	logic [37:0] pkt_shift = '0;
	logic [5:0]  bits_left = '0;
	logic [2:0]  gain2_shadow = '0;
	logic [6:0]  gain1_shadow = '0;
	logic [7:0]  offset_shadow = '0;

	// Results predicted for accepted beats, oldest first.
	sender_result_t pending_results[$];

	bit          idling = 1'b1;
	int unsigned items_sent = 0;
	int unsigned beats_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned ready_hold = 0;

	pulse_width_parameter_packet_sender DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// A programmed length of zero behaves as one tick.
	function automatic logic [15:0] ticks_or_one(input logic [15:0] t);
		return (t == 16'd0) ? 16'd1 : t;
	endfunction

	// Enter the high pulse of the bit now at the top of the packet: long
	// for a one, short for a zero. Lengths are read at this moment.
	function automatic void load_bit_pulse();
		ph = PH_HIGH;
		ph_left = ticks_or_one(pkt_shift[37] ? long_len : short_len);
	endfunction

	// Frame a packet, MSB first: start word, function, parameter, dummy,
	// value, end word. Loading it enters the first pulse without a tick.
	function automatic void start_packet(input logic [1:0] fn, input logic [1:0] sel,
			input logic [7:0] val);
		pkt_shift = {pwpps_pkg::START_WORD, fn, sel, pwpps_pkg::DUMMY_BITS, val,
			pwpps_pkg::END_WORD};
		bits_left = 6'(pwpps_pkg::PKT_BITS);
		load_bit_pulse();
	endfunction

	// Work out the result of one accepted beat and advance the state.
	function automatic sender_result_t predict_sender(input logic [1:0] op,
			input logic [1:0] sel, input logic [7:0] val);
		sender_result_t r;
		logic [7:0] masked;
		r = '0;
		masked = '0;
		// The pin level reported is the one held before this beat is applied.
		r.pin = (ph == PH_HIGH);
		case (op)
		pwpps_pkg::OP_TICK: begin
			case (ph)
			PH_HIGH: begin
				if (ph_left <= 16'd1) begin
					ph = PH_GAP;
					ph_left = ticks_or_one(gap_len);
				end else begin
					ph_left = ph_left - 16'd1;
				end
			end
			PH_GAP: begin
				if (ph_left <= 16'd1) begin
					// End of a bit: shift the next one up, or go idle after
					// the last one.
					pkt_shift = pkt_shift << 1;
					bits_left = bits_left - 6'd1;
					if (bits_left == 6'd0) begin
						ph = PH_IDLE;
						ph_left = '0;
					end else begin
						load_bit_pulse();
					end
				end else begin
					ph_left = ph_left - 16'd1;
				end
			end
			default: ph = PH_IDLE;
			endcase
		end
		pwpps_pkg::OP_WRITE, pwpps_pkg::OP_READ: begin
			// A busy sender turns away every command, even one with the
			// spare selector; an idle one ignores the spare selector.
			if (ph != PH_IDLE) begin
				r.rejected = 1'b1;
			end else if (sel != SEL_NONE) begin
				r.accepted = 1'b1;
				if (op == pwpps_pkg::OP_WRITE) begin
					case (sel)
					pwpps_pkg::SEL_GAIN2: begin
						masked = val & pwpps_pkg::MASK_GAIN2;
						gain2_shadow = masked[2:0];
					end
					pwpps_pkg::SEL_GAIN1: begin
						masked = val & pwpps_pkg::MASK_GAIN1;
						gain1_shadow = masked[6:0];
					end
					default: begin
						masked = val & pwpps_pkg::MASK_OFFSET;
						offset_shadow = masked;
					end
					endcase
					start_packet(pwpps_pkg::FN_SIMULATE, sel, masked);
				end else begin
					case (sel)
					pwpps_pkg::SEL_GAIN2: r.read_value = {5'd0, gain2_shadow};
					pwpps_pkg::SEL_GAIN1: r.read_value = {1'b0, gain1_shadow};
					default:              r.read_value = offset_shadow;
					endcase
					start_packet(pwpps_pkg::FN_READ, sel, 8'd0);
				end
			end
		end
		default: ;   // spare op code: no effect at all
		endcase
		r.busy = (ph != PH_IDLE);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	// Print one line per mismatch and count every one of them.
	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("mismatch in result beat %0d, %s: got 'h%0h, expected 'h%0h",
			beats_seen, field, got, want);
	endtask

	// Every result beat taken by the bench is matched against the oldest
	// prediction. Values are sampled at the edge, before any update lands.
	always @(posedge clk) begin : check_results
		sender_result_t got;
		sender_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[11:0];
			if (pending_results.size() == 0) begin
				report_mismatch("beat with nothing expected", 32'(m_axis_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.pin !== want.pin)
					report_mismatch("pin_level", 32'(got.pin), 32'(want.pin));
				if (got.busy !== want.busy)
					report_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
				if (got.read_value !== want.read_value)
					report_mismatch("read_value", 32'(got.read_value),
						32'(want.read_value));
				if (got.accepted !== want.accepted)
					report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
				if (got.rejected !== want.rejected)
					report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
			end
			beats_seen++;
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Output back-pressure: random stall bursts while idling is on, ready
	// held high otherwise.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!idling)
			ready_hold = 0;
		else if (ready_hold == 0 && $urandom_range(0, 7) == 0)
			ready_hold = $urandom_range(1, 17);
		if (ready_hold != 0) begin
			m_axis_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Shared stimulus tasks
	// ------------------------------------------------------------------------

	// Offer one beat and wait for its handshake. tvalid stays high on return
	// so that the next beat can follow without a bubble; whoever stops
	// sending lowers it.
	task automatic send_item(input logic [1:0] op, input logic [1:0] sel,
			input logic [7:0] val);
		int unsigned gap;
		if (idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, val, sel};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_sender(op, sel, val));
		items_sent++;
	endtask

	// Stop sending, wait until every predicted result has been received,
	// then let the block settle before returning so it is truly quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Program all three timing registers once no beat is outstanding.
	task automatic set_timing(input logic [15:0] long_t, input logic [15:0] short_t,
			input logic [15:0] gap_t);
		settle();
		write_reg(pwpps_pkg::REG_LONG, long_t);
		write_reg(pwpps_pkg::REG_SHORT, short_t);
		write_reg(pwpps_pkg::REG_GAP, gap_t);
		cfg_we <= 1'b0;
		long_len = long_t;
		short_len = short_t;
		gap_len = gap_t;
	endtask

	// Tick the current packet out until the sender goes idle or max_items
	// beats have been sent. With noise_pct percent, a stray beat goes in
	// instead of a tick: a command (rejected while busy) or the spare op.
	task automatic clock_out(input int unsigned noise_pct, input int unsigned max_items);
		int unsigned n;
		n = 0;
		while (ph != PH_IDLE && n < max_items) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(2'($urandom_range(1, 3)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
			else
				send_item(pwpps_pkg::OP_TICK, 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
			n++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Beats that must leave an idle sender alone: a tick while idle, the
	// spare op code, and commands with the spare selector.
	task automatic test_idle_items();
		send_item(pwpps_pkg::OP_TICK, pwpps_pkg::SEL_GAIN2, 8'h00);
		send_item(OP_NONE, pwpps_pkg::SEL_OFFSET, 8'hFF);
		send_item(pwpps_pkg::OP_WRITE, SEL_NONE, 8'hFF);
		send_item(pwpps_pkg::OP_READ, SEL_NONE, 8'h00);
		send_item(OP_NONE, SEL_NONE, 8'h55);
		send_item(pwpps_pkg::OP_TICK, SEL_NONE, 8'hAA);
	endtask

	// The first bits of a packet at the reset pulse and gap lengths, which
	// also shows that the shadows come out of reset at zero. The lengths
	// then shrink in the middle of the packet, which takes effect at the
	// next phase load, and the packet is ticked out to the end.
	task automatic test_reset_timing();
		send_item(pwpps_pkg::OP_READ, pwpps_pkg::SEL_GAIN1, 8'hAA);
		clock_out(0, 150);
		set_timing(16'd1, 16'd1, 16'd1);
		clock_out(0, 32'hFFFF_FFFF);
	endtask

	// Zero in every timing register behaves as one tick; commands thrown in
	// during the packet must all be turned away.
	task automatic test_zero_lengths();
		set_timing(16'd0, 16'd0, 16'd0);
		send_item(pwpps_pkg::OP_WRITE, pwpps_pkg::SEL_GAIN2, 8'hFF);
		clock_out(15, 32'hFFFF_FFFF);
	endtask

	// Each parameter is masked to its own width on write and read back
	// from its shadow.
	task automatic test_param_masks();
		logic [1:0] sel;
		set_timing(16'd1, 16'd1, 16'd1);
		for (int i = 0; i < 3; i++) begin
			sel = 2'(i);
			send_item(pwpps_pkg::OP_WRITE, sel, 8'hFF);
			clock_out(0, 32'hFFFF_FFFF);
			send_item(pwpps_pkg::OP_READ, sel, 8'h00);
			clock_out(0, 32'hFFFF_FFFF);
		end
	endtask

	// Mostly well-formed traffic: a command, then ticks until the packet is
	// done, with stray beats mixed in. Timing changes between packets now
	// and then, and some stretches run with no idling on either side.
	task automatic test_random_traffic();
		int unsigned start_count;
		logic [1:0] op;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				set_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
					16'($urandom_range(0, 3)));
			idling = ($urandom_range(0, 3) != 0);
			// Noise on the idle sender before the command.
			repeat ($urandom_range(0, 3)) begin
				op = 2'($urandom_range(0, 3));
				send_item(op, (op == pwpps_pkg::OP_WRITE || op == pwpps_pkg::OP_READ) ?
					SEL_NONE : 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
			send_item($urandom_range(0, 1) ? pwpps_pkg::OP_WRITE : pwpps_pkg::OP_READ,
				2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
			clock_out(8, 32'hFFFF_FFFF);
		end
	endtask

	// Largest lengths in every register. The first bit of any packet is a
	// one, so the line must stay high for the whole of this stretch. The
	// packet is left unfinished: it would take millions of ticks.
	task automatic test_max_lengths();
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		idling = 1'b0;
		send_item(pwpps_pkg::OP_WRITE, pwpps_pkg::SEL_OFFSET, 8'h81);
		clock_out(5, 100);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_items();
		test_reset_timing();
		test_zero_lengths();
		test_param_masks();
		test_random_traffic();
		test_max_lengths();

		settle();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
